[src/pca_pkg.sv]
// Package with the shared types and constants of the polygon centroid and area block.
package pca_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_COORD_BITS   = 24;

    localparam int COORD_IN_W  = 24;
    localparam int CENT_W      = 24;
    localparam int AREA_W      = 41;
    localparam int AREA_SHIFT  = 13;
    localparam int MIN_VERTS   = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 96;

    localparam logic [AREA_W-1:0] MIN_AREA_RESET = AREA_W'(1);

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FEW   = 2'd1,
        STATUS_SMALL = 2'd2,
        STATUS_MANY  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUB,
        ST_CLOSE,
        ST_DIV_LD,
        ST_DIV,
        ST_AREA,
        ST_DONE
    } state_t;

endpackage

[src/polygon_centroid_area.sv]
// Streaming shoelace area and vertex-average centroid of one polygon, on a shared multiplier.
//
//  Channel  | Ports                     | Carries
//  ---------+---------------------------+------------------------------------------------
//  input    | s_tvalid s_tready s_tdata | one vertex request (x, y), s_tlast on the last
//  result   | m_tvalid m_tready m_tdata | centroid_x, centroid_y, area, status
//  config   | cfg_we cfg_wdata          | min_area register
//
// For each vertex, the shared multiplier forms both edge products in turn.
// The first vertex of a polygon and a vertex past MAX_VERTICES skip the multiplier.
// The closing vertex adds the closing edge and two restoring divisions of the coordinate
// sums by the count, one quotient bit per cycle, unless the count is out of range.
// aresetn is synchronous, active low; it clears the sequencer and count, sets min_area to 1.
// A finished result waits in the output register while new vertices are taken; the block
// stalls only when a second result is ready before the first has been taken.
module polygon_centroid_area #(
    parameter int MAX_VERTICES = pca_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = pca_pkg::DEF_COORD_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // x [23:0], y [47:24]
    input  logic [pca_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // centroid_x [23:0], centroid_y [47:24], area [88:48], status [90:89], zeros above
    output logic [pca_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_we,
    input  logic [pca_pkg::AREA_W-1:0]       cfg_wdata
);

    localparam int CNT_W   = $clog2(MAX_VERTICES + 2);
    localparam int SUM_W   = COORD_BITS + $clog2(MAX_VERTICES) + 1;
    localparam int PROD_W  = 2 * COORD_BITS;
    localparam int CROSS_W = PROD_W + $clog2(MAX_VERTICES + 1) + 1;
    localparam int EXT_W   = (CROSS_W > pca_pkg::AREA_W + pca_pkg::AREA_SHIFT) ?
                             CROSS_W : pca_pkg::AREA_W + pca_pkg::AREA_SHIFT;
    localparam int BIT_W   = (SUM_W > 1) ? $clog2(SUM_W) : 1;
    localparam int OUT_PAD = pca_pkg::OUT_TDATA_W - 2 * pca_pkg::CENT_W - pca_pkg::AREA_W - 2;

    pca_pkg::state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] x_in, y_in;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg;
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic                         last_reg;
    logic                         closing_reg;
    logic signed [SUM_W-1:0]      sum_x_reg, sum_y_reg;
    logic signed [CROSS_W-1:0]    cross_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [pca_pkg::AREA_W-1:0]   min_area_reg;

    logic signed [COORD_BITS-1:0] op_a, op_b;
    logic signed [PROD_W-1:0]     prod_c, prod_reg;

    logic                         div_y_reg;
    logic                         neg_reg;
    logic [SUM_W-1:0]             quo_reg;
    logic [CNT_W-1:0]             rem_reg;
    logic [BIT_W-1:0]             bit_reg;
    logic [CNT_W:0]               rem_sh;
    logic [CNT_W+1:0]             rem_diff;
    logic                         div_fit;
    logic [SUM_W-1:0]             div_src;
    logic [SUM_W-1:0]             quo_last;
    logic signed [SUM_W-1:0]      quo_signed;
    logic [pca_pkg::CENT_W-1:0]   quo_out;

    logic [CROSS_W-1:0]           cross_mag;
    logic [EXT_W-1:0]             area_ext;
    logic [pca_pkg::AREA_W-1:0]   area_c;

    logic [pca_pkg::CENT_W-1:0]   cx_reg, cy_reg;
    logic [pca_pkg::AREA_W-1:0]   area_reg;
    pca_pkg::status_t             status_reg;

    logic                         m_tvalid_reg;
    logic [pca_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                         out_free;
    logic                         few_verts, many_verts;

    generate
        if (COORD_BITS <= pca_pkg::COORD_IN_W) begin : g_coord_narrow
            assign x_in = s_tdata[COORD_BITS-1:0];
            assign y_in = s_tdata[pca_pkg::COORD_IN_W +: COORD_BITS];
        end else begin : g_coord_wide
            assign x_in = COORD_BITS'(s_tdata[pca_pkg::COORD_IN_W-1:0]);
            assign y_in = COORD_BITS'(s_tdata[2*pca_pkg::COORD_IN_W-1:pca_pkg::COORD_IN_W]);
        end
    endgenerate

    assign out_free   = !m_tvalid_reg || m_tready;
    assign few_verts  = count_reg < CNT_W'(pca_pkg::MIN_VERTS);
    assign many_verts = count_reg > CNT_W'(MAX_VERTICES);

    always_comb begin
        if (state_reg == pca_pkg::ST_MUL_A) begin
            op_a = prev_x_reg;
            op_b = closing_reg ? first_y_reg : cur_y_reg;
        end else begin
            op_a = closing_reg ? first_x_reg : cur_x_reg;
            op_b = prev_y_reg;
        end
        prod_c = PROD_W'(op_a) * PROD_W'(op_b);
    end

    always_comb begin
        rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
        rem_diff = {1'b0, rem_sh} - {2'b00, count_reg};
        div_fit  = !rem_diff[CNT_W+1];
        div_src  = div_y_reg ? SUM_W'(sum_y_reg) : SUM_W'(sum_x_reg);
        quo_last = {quo_reg[SUM_W-2:0], div_fit};
        quo_signed = neg_reg ? -$signed(quo_last) : $signed(quo_last);
        quo_out  = pca_pkg::CENT_W'(quo_signed);
    end

    always_comb begin
        cross_mag = cross_reg[CROSS_W-1] ? CROSS_W'(-cross_reg) : CROSS_W'(cross_reg);
        area_ext  = EXT_W'(cross_mag) >> pca_pkg::AREA_SHIFT;
        if (|area_ext[EXT_W-1:pca_pkg::AREA_W]) begin
            area_c = '1;
        end else begin
            area_c = area_ext[pca_pkg::AREA_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pca_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = pca_pkg::ST_EVAL;
            end
            pca_pkg::ST_EVAL: begin
                if (count_reg != '0 && count_reg < CNT_W'(MAX_VERTICES)) begin
                    state_next = pca_pkg::ST_MUL_A;
                end else begin
                    state_next = last_reg ? pca_pkg::ST_CLOSE : pca_pkg::ST_IDLE;
                end
            end
            pca_pkg::ST_MUL_A: state_next = pca_pkg::ST_MUL_B;
            pca_pkg::ST_MUL_B: state_next = pca_pkg::ST_SUB;
            pca_pkg::ST_SUB: begin
                priority if (closing_reg) begin
                    state_next = pca_pkg::ST_DIV_LD;
                end else if (last_reg) begin
                    state_next = pca_pkg::ST_CLOSE;
                end else begin
                    state_next = pca_pkg::ST_IDLE;
                end
            end
            pca_pkg::ST_CLOSE: begin
                if (few_verts || many_verts) begin
                    state_next = pca_pkg::ST_DONE;
                end else begin
                    state_next = pca_pkg::ST_MUL_A;
                end
            end
            pca_pkg::ST_DIV_LD: state_next = pca_pkg::ST_DIV;
            pca_pkg::ST_DIV: begin
                if (bit_reg == '0) begin
                    state_next = div_y_reg ? pca_pkg::ST_AREA : pca_pkg::ST_DIV_LD;
                end
            end
            pca_pkg::ST_AREA: state_next = pca_pkg::ST_DONE;
            pca_pkg::ST_DONE: begin
                if (out_free) state_next = pca_pkg::ST_IDLE;
            end
            default: state_next = pca_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == pca_pkg::ST_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_tdata_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pca_pkg::ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            min_area_reg <= pca_pkg::MIN_AREA_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_we) min_area_reg <= cfg_wdata;
            if (state_reg == pca_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                pca_pkg::ST_IDLE: begin
                    if (s_tvalid) begin
                        cur_x_reg   <= x_in;
                        cur_y_reg   <= y_in;
                        last_reg    <= s_tlast;
                        closing_reg <= 1'b0;
                    end
                end
                pca_pkg::ST_EVAL: begin
                    if (count_reg == '0) begin
                        first_x_reg <= cur_x_reg;
                        first_y_reg <= cur_y_reg;
                        prev_x_reg  <= cur_x_reg;
                        prev_y_reg  <= cur_y_reg;
                        sum_x_reg   <= SUM_W'(cur_x_reg);
                        sum_y_reg   <= SUM_W'(cur_y_reg);
                        cross_reg   <= '0;
                        count_reg   <= CNT_W'(1);
                    end else if (count_reg >= CNT_W'(MAX_VERTICES)) begin
                        count_reg <= CNT_W'(MAX_VERTICES + 1);
                    end
                end
                pca_pkg::ST_MUL_A: begin
                    prod_reg <= prod_c;
                end
                pca_pkg::ST_MUL_B: begin
                    cross_reg <= cross_reg + CROSS_W'(prod_reg);
                    prod_reg  <= prod_c;
                end
                pca_pkg::ST_SUB: begin
                    cross_reg <= cross_reg - CROSS_W'(prod_reg);
                    if (!closing_reg) begin
                        prev_x_reg <= cur_x_reg;
                        prev_y_reg <= cur_y_reg;
                        sum_x_reg  <= sum_x_reg + SUM_W'(cur_x_reg);
                        sum_y_reg  <= sum_y_reg + SUM_W'(cur_y_reg);
                        count_reg  <= count_reg + CNT_W'(1);
                    end
                    div_y_reg <= 1'b0;
                end
                pca_pkg::ST_CLOSE: begin
                    closing_reg <= 1'b1;
                    cx_reg      <= '0;
                    cy_reg      <= '0;
                    area_reg    <= '0;
                    if (few_verts) begin
                        status_reg <= pca_pkg::STATUS_FEW;
                    end else begin
                        status_reg <= pca_pkg::STATUS_MANY;
                    end
                end
                pca_pkg::ST_DIV_LD: begin
                    neg_reg <= div_src[SUM_W-1];
                    quo_reg <= div_src[SUM_W-1] ? -div_src : div_src;
                    rem_reg <= '0;
                    bit_reg <= BIT_W'(SUM_W - 1);
                end
                pca_pkg::ST_DIV: begin
                    quo_reg <= quo_last;
                    rem_reg <= div_fit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                    bit_reg <= bit_reg - BIT_W'(1);
                    if (bit_reg == '0) begin
                        if (div_y_reg) begin
                            cy_reg <= quo_out;
                        end else begin
                            cx_reg <= quo_out;
                        end
                        div_y_reg <= 1'b1;
                    end
                end
                pca_pkg::ST_AREA: begin
                    area_reg   <= area_c;
                    status_reg <= (area_c < min_area_reg) ? pca_pkg::STATUS_SMALL :
                                                            pca_pkg::STATUS_OK;
                end
                pca_pkg::ST_DONE: begin
                    if (out_free) begin
                        m_tdata_reg  <= {OUT_PAD'(0), status_reg, area_reg, cy_reg, cx_reg};
                        count_reg    <= '0;
                        cross_reg    <= '0;
                    end
                end
                default: begin
                    count_reg <= '0;
                end
            endcase
        end
    end

endmodule
